// File: sv/atan2ra_pkg.sv
// Shared widths, fixed-point formats and the sideband type of the atan2 core.
// No dependencies; imported by every module of the block.
`default_nettype none

package atan2ra_pkg;

	// Input components, two's complement.
	localparam int IN_W       = 16;
	// Fraction bits of the output angle; the angle word has three integer bits.
	localparam int ANGLE_FRAC = 13;
	localparam int ANGLE_W    = ANGLE_FRAC + 3;

	// Magnitudes of the inputs fit an unsigned word of the input width.
	localparam int MAG_W      = IN_W;

	// The ratio of the smaller to the larger magnitude is Q1.15, at most one.
	localparam int RATIO_FRAC = 15;
	localparam int R_W        = RATIO_FRAC + 1;

	// Polynomial arithmetic is carried in Q30 within a 32-bit word.
	localparam int Q_FRAC     = 30;
	localparam int Q_W        = 32;

	// The atan magnitude in angle format never exceeds one plus one LSB.
	localparam int M_W        = ANGLE_FRAC + 1;

	// Quotient bits resolved per pipeline stage in both dividers.
	localparam int DIV_STEP   = 2;

	// Quadrant information that travels alongside each beat.
	typedef struct packed {
		logic xdom;
		logic x_neg;
		logic y_neg;
		logic zero;
	} side_t;

endpackage

`default_nettype wire

// File: sv/atan2ra_ratio_div.sv
// Pipelined restoring divider giving the rounded ratio min/max in Q1.15.
// Depends on atan2ra_pkg; instantiated by atan2_rational_approx_core.
`default_nettype none

module atan2ra_ratio_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire atan2ra_pkg::side_t           in_side,
	input  wire logic [atan2ra_pkg::MAG_W-1:0] mn,
	input  wire logic [atan2ra_pkg::MAG_W-1:0] mx,
	output logic                              out_valid,
	output atan2ra_pkg::side_t                out_side,
	output logic [atan2ra_pkg::R_W-1:0]       ratio
);
	import atan2ra_pkg::*;

	localparam int N_W    = MAG_W + R_W;
	localparam int STAGES = (R_W + DIV_STEP - 1) / DIV_STEP;

	// Numerator with the rounding half of the divisor already added.
	logic [N_W-1:0] num;
	assign num = ({{R_W{1'b0}}, mn} << RATIO_FRAC) + {{(R_W + 1){1'b0}}, mx[MAG_W-1:1]};

	logic [MAG_W-1:0] rem_s  [STAGES];
	logic [MAG_W-1:0] mx_s   [STAGES];
	logic [R_W-1:0]   low_s  [STAGES];
	logic [R_W-1:0]   quo_s  [STAGES];
	side_t            side_s [STAGES];
	logic             valid_s[STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [MAG_W-1:0] rem_in;
		logic [MAG_W-1:0] mx_in;
		logic [R_W-1:0]   low_in;
		logic [R_W-1:0]   quo_in;
		side_t            side_in;
		logic             valid_in;
		logic [MAG_W-1:0] rem_nx;
		logic [R_W-1:0]   low_nx;
		logic [R_W-1:0]   quo_nx;
		logic [MAG_W:0]   trial;
		logic [MAG_W:0]   diff;

		if (g == 0) begin : g_first
			// The quotient is at most one in Q1.15, so the upper part of the
			// numerator is already below the divisor.
			assign rem_in   = num[N_W-1:R_W];
			assign low_in   = num[R_W-1:0];
			assign quo_in   = '0;
			assign mx_in    = mx;
			assign side_in  = in_side;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_s[g-1];
			assign low_in   = low_s[g-1];
			assign quo_in   = quo_s[g-1];
			assign mx_in    = mx_s[g-1];
			assign side_in  = side_s[g-1];
			assign valid_in = valid_s[g-1];
		end

		always_comb begin
			rem_nx = rem_in;
			low_nx = low_in;
			quo_nx = quo_in;
			trial  = '0;
			diff   = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				if (g * DIV_STEP + j < R_W) begin
					trial = {rem_nx, low_nx[R_W-1]};
					diff  = trial - {1'b0, mx_in};
					if (trial >= {1'b0, mx_in}) begin
						rem_nx = diff[MAG_W-1:0];
						quo_nx = {quo_nx[R_W-2:0], 1'b1};
					end else begin
						rem_nx = trial[MAG_W-1:0];
						quo_nx = {quo_nx[R_W-2:0], 1'b0};
					end
					low_nx = {low_nx[R_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (en) begin
				valid_s[g] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_nx;
				low_s[g]  <= low_nx;
				quo_s[g]  <= quo_nx;
				mx_s[g]   <= mx_in;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];
	assign ratio     = quo_s[STAGES-1];

endmodule

`default_nettype wire

// File: sv/atan2ra_atan_eval.sv
// Rational approximation of atan(r): a Q30 polynomial pipeline for the
// denominator followed by a pipelined divider. Depends on atan2ra_pkg.
`default_nettype none

module atan2ra_atan_eval (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire atan2ra_pkg::side_t         in_side,
	input  wire logic [atan2ra_pkg::R_W-1:0] ratio,
	output logic                            out_valid,
	output atan2ra_pkg::side_t              out_side,
	output logic [atan2ra_pkg::M_W-1:0]     atan_mag
);
	import atan2ra_pkg::*;

	localparam logic [Q_W-1:0]   COEF_A = 32'd357437384;
	localparam logic [Q_W-1:0]   COEF_B = 32'd90924375;
	localparam logic [Q_W-1:0]   COEF_C = 32'd34920582;
	localparam logic [Q_W-1:0]   COEF_D = 32'd8045610;
	localparam logic [Q_W-1:0]   Q_ONE  = Q_W'(64'd1 << Q_FRAC);
	localparam logic [2*Q_W-1:0] Q_HALF = (2*Q_W)'(1) << (Q_FRAC - 1);

	localparam int N_W    = R_W + RATIO_FRAC + ANGLE_FRAC;
	localparam int HI_W   = N_W - M_W;
	localparam int STAGES = (M_W + DIV_STEP - 1) / DIV_STEP;

	// Q30 product rounded half up.
	function automatic logic [Q_W-1:0] q_mul(input logic [Q_W-1:0] p, input logic [Q_W-1:0] q);
		logic [2*Q_W-1:0] prod;
		prod = {{Q_W{1'b0}}, p} * {{Q_W{1'b0}}, q} + Q_HALF;
		return prod[Q_FRAC +: Q_W];
	endfunction

	// Polynomial stages. Each holds at most two multipliers and at most one add or subtract.
	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	side_t            side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [R_W-1:0]   r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
	logic [Q_W-1:0]   u_s1, u_s2, u_s3;
	logic [Q_W-1:0]   u2_s2, u3_s3, u4_s4;
	logic [Q_W-1:0]   ta_s2, tb_s3, tc_s4, td_s5;
	logic [Q_W-1:0]   acc_s3, acc_s4, acc_s5;
	logic [Q_W-1:0]   f_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// The running sum stays positive throughout, so plain modular words suffice.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			r_s1    <= ratio;
			u_s1    <= Q_W'({{R_W{1'b0}}, ratio} * {{R_W{1'b0}}, ratio});

			side_s2 <= side_s1;
			r_s2    <= r_s1;
			u_s2    <= u_s1;
			u2_s2   <= q_mul(u_s1, u_s1);
			ta_s2   <= q_mul(COEF_A, u_s1);

			side_s3 <= side_s2;
			r_s3    <= r_s2;
			u_s3    <= u_s2;
			u3_s3   <= q_mul(u2_s2, u_s2);
			tb_s3   <= q_mul(COEF_B, u2_s2);
			acc_s3  <= Q_ONE + ta_s2;

			side_s4 <= side_s3;
			r_s4    <= r_s3;
			u4_s4   <= q_mul(u3_s3, u_s3);
			tc_s4   <= q_mul(COEF_C, u3_s3);
			acc_s4  <= acc_s3 - tb_s3;

			side_s5 <= side_s4;
			r_s5    <= r_s4;
			td_s5   <= q_mul(COEF_D, u4_s4);
			acc_s5  <= acc_s4 + tc_s4;

			side_s6 <= side_s5;
			r_s6    <= r_s5;
			f_s6    <= acc_s5 - td_s5;
		end
	end

	// Divider: r scaled to the angle format over f, rounded half up.
	logic [N_W-1:0] num;
	assign num = ({{(N_W - R_W){1'b0}}, r_s6} << (RATIO_FRAC + ANGLE_FRAC))
		+ {{(N_W - Q_W){1'b0}}, f_s6 >> 1};

	logic [Q_W-1:0] rem_d  [STAGES];
	logic [Q_W-1:0] f_d    [STAGES];
	logic [M_W-1:0] low_d  [STAGES];
	logic [M_W-1:0] quo_d  [STAGES];
	side_t          side_d [STAGES];
	logic           valid_d[STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [Q_W-1:0] rem_in;
		logic [Q_W-1:0] f_in;
		logic [M_W-1:0] low_in;
		logic [M_W-1:0] quo_in;
		side_t          side_in;
		logic           valid_in;
		logic [Q_W-1:0] rem_nx;
		logic [M_W-1:0] low_nx;
		logic [M_W-1:0] quo_nx;
		logic [Q_W:0]   trial;
		logic [Q_W:0]   diff;

		if (g == 0) begin : g_first
			// The numerator above the quotient bits is below f, which is at least one.
			assign rem_in   = {{(Q_W - HI_W){1'b0}}, num[N_W-1:M_W]};
			assign low_in   = num[M_W-1:0];
			assign quo_in   = '0;
			assign f_in     = f_s6;
			assign side_in  = side_s6;
			assign valid_in = valid_s6;
		end else begin : g_next
			assign rem_in   = rem_d[g-1];
			assign low_in   = low_d[g-1];
			assign quo_in   = quo_d[g-1];
			assign f_in     = f_d[g-1];
			assign side_in  = side_d[g-1];
			assign valid_in = valid_d[g-1];
		end

		always_comb begin
			rem_nx = rem_in;
			low_nx = low_in;
			quo_nx = quo_in;
			trial  = '0;
			diff   = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				if (g * DIV_STEP + j < M_W) begin
					trial = {rem_nx, low_nx[M_W-1]};
					diff  = trial - {1'b0, f_in};
					if (trial >= {1'b0, f_in}) begin
						rem_nx = diff[Q_W-1:0];
						quo_nx = {quo_nx[M_W-2:0], 1'b1};
					end else begin
						rem_nx = trial[Q_W-1:0];
						quo_nx = {quo_nx[M_W-2:0], 1'b0};
					end
					low_nx = {low_nx[M_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_d[g] <= 1'b0;
			end else if (en) begin
				valid_d[g] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[g]  <= rem_nx;
				low_d[g]  <= low_nx;
				quo_d[g]  <= quo_nx;
				f_d[g]    <= f_in;
				side_d[g] <= side_in;
			end
		end
	end

	assign out_valid = valid_d[STAGES-1];
	assign out_side  = side_d[STAGES-1];
	assign atan_mag  = quo_d[STAGES-1];

endmodule

`default_nettype wire

// File: sv/atan2_rational_approx_core.sv
// Top level of the four-quadrant atan2 core: magnitude compare, ratio divider,
// atan evaluation, quadrant correction and output skid. Uses atan2ra_pkg,
// atan2ra_ratio_div and atan2ra_atan_eval.
//
// Usage
//   Input beats carry x_value and y_value (signed integers) on in_valid and are
//   taken at a clock edge where in_valid is high and in_stall is low. Result
//   beats carry angle (radians, Q3.13) and both_zero on out_valid, and are taken
//   where out_valid is high and out_stall is low. With x and y both zero the
//   angle is zero and both_zero is set.
//   One beat is accepted every clock while in_stall is low. A result passes
//   through these registers in order: the magnitude compare register loads at
//   the edge that takes its input beat, then come eight stages of the ratio divider,
//   six of the Q30 denominator polynomial, seven of the second divider, one for
//   the quadrant correction and the result register. The dividers resolve two
//   quotient bits per stage, which sets the depth.
//   When the receiver stalls, the result register holds its beat and the next
//   one lands in a skid register; only then is in_stall raised and the whole
//   pipeline frozen, so nothing is dropped or repeated.
//   The asynchronous reset empties every stage and both output registers.
`default_nettype none

module atan2_rational_approx_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [atan2ra_pkg::IN_W-1:0]   x_value,
	input  wire logic signed [atan2ra_pkg::IN_W-1:0]   y_value,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [atan2ra_pkg::ANGLE_W-1:0]     angle,
	output logic                                       both_zero
);
	import atan2ra_pkg::*;

	localparam int               ANG_SH      = Q_FRAC - ANGLE_FRAC;
	localparam logic [63:0]      PI_Q30      = 64'd3373259426;
	localparam logic [63:0]      HALFPI_Q30  = 64'd1686629713;
	localparam logic [ANGLE_W-1:0] PI_ANG    =
		ANGLE_W'((PI_Q30 + (64'd1 << (ANG_SH - 1))) >> ANG_SH);
	localparam logic [ANGLE_W-1:0] HALFPI_ANG =
		ANGLE_W'((HALFPI_Q30 + (64'd1 << (ANG_SH - 1))) >> ANG_SH);
	localparam logic [ANGLE_W-1:0] NEG_PI_ANG     = ANGLE_W'(0) - PI_ANG;
	localparam logic [ANGLE_W-1:0] NEG_HALFPI_ANG = ANGLE_W'(0) - HALFPI_ANG;

	logic en;
	logic skid_valid_q;
	logic out_valid_q;

	// The pipeline moves whenever the skid register is free.
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// Stage 1: magnitudes and which component dominates.
	logic [IN_W-1:0]  xu, yu;
	logic [MAG_W-1:0] ax, ay;
	side_t            side_in;

	assign xu = x_value;
	assign yu = y_value;
	assign ax = xu[IN_W-1] ? (~xu + IN_W'(1)) : xu;
	assign ay = yu[IN_W-1] ? (~yu + IN_W'(1)) : yu;

	always_comb begin
		side_in.xdom  = ax > ay;
		side_in.x_neg = xu[IN_W-1];
		side_in.y_neg = yu[IN_W-1];
		side_in.zero  = (ax == '0) && (ay == '0);
	end

	logic             valid_s1;
	side_t            side_s1;
	logic [MAG_W-1:0] mn_s1, mx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			mn_s1   <= side_in.xdom ? ay : ax;
			mx_s1   <= side_in.xdom ? ax : ay;
		end
	end

	logic           ratio_valid;
	side_t          ratio_side;
	logic [R_W-1:0] ratio;

	atan2ra_ratio_div u_ratio_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_side   (side_s1),
		.mn        (mn_s1),
		.mx        (mx_s1),
		.out_valid (ratio_valid),
		.out_side  (ratio_side),
		.ratio     (ratio)
	);

	logic           atan_valid;
	side_t          atan_side;
	logic [M_W-1:0] atan_mag;

	atan2ra_atan_eval u_atan_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ratio_valid),
		.in_side   (ratio_side),
		.ratio     (ratio),
		.out_valid (atan_valid),
		.out_side  (atan_side),
		.atan_mag  (atan_mag)
	);

	// Final stage: sign of the ratio and the quadrant offset, in modular arithmetic.
	logic [ANGLE_W-1:0] mag, t, ang;

	always_comb begin
		mag = {{(ANGLE_W - M_W){1'b0}}, atan_mag};
		t   = (atan_side.x_neg ^ atan_side.y_neg) ? (ANGLE_W'(0) - mag) : mag;
		if (atan_side.zero) begin
			ang = '0;
		end else if (atan_side.xdom) begin
			if (!atan_side.x_neg) begin
				ang = t;
			end else if (atan_side.y_neg) begin
				ang = t + NEG_PI_ANG;
			end else begin
				ang = t + PI_ANG;
			end
		end else begin
			// Here y is never zero, so its sign picks the half plane.
			ang = (atan_side.y_neg ? NEG_HALFPI_ANG : HALFPI_ANG) - t;
		end
	end

	logic               valid_s2;
	logic [ANGLE_W-1:0] angle_s2;
	logic               zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= atan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s2 <= ang;
			zero_s2  <= atan_side.zero;
		end
	end

	// Output register with a skid register behind it.
	logic [ANGLE_W-1:0] angle_q, skid_angle_q;
	logic               both_zero_q, skid_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s2;
		end else begin
			skid_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				angle_q     <= skid_angle_q;
				both_zero_q <= skid_zero_q;
			end
		end else if (!out_valid_q || !out_stall) begin
			angle_q     <= angle_s2;
			both_zero_q <= zero_s2;
		end else begin
			skid_angle_q <= angle_s2;
			skid_zero_q  <= zero_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign both_zero = both_zero_q;

endmodule

`default_nettype wire

// File: tb/sv/atan2_rational_approx_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the atan2 core: predicts the angle of every accepted input beat
// and compares each accepted result beat in order. Depends on atan2ra_pkg only.

module atan2_rational_approx_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [atan2ra_pkg::IN_W-1:0]   x_value,
	input  logic signed [atan2ra_pkg::IN_W-1:0]   y_value,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [atan2ra_pkg::ANGLE_W-1:0] angle,
	input  logic                                  both_zero,
	output int                                    mismatch_count,
	output int                                    results_due
);
	import atan2ra_pkg::*;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		logic                      both_zero;
	} atan_result_t;

	// Rational approximation coefficients and angle constants, all Q30.
	localparam longint unsigned Q30_UNITY   = 64'd1073741824;
	localparam longint unsigned Q30_ROUND   = 64'd536870912;
	localparam longint unsigned K_A         = 64'd357437384;
	localparam longint unsigned K_B         = 64'd90924375;
	localparam longint unsigned K_C         = 64'd34920582;
	localparam longint unsigned K_D         = 64'd8045610;
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int              ANGLE_SHIFT = Q_FRAC - ANGLE_FRAC;

	atan_result_t expected_angles[$];
	int           mismatches;

	function automatic longint unsigned q30_product(input longint unsigned p,
			input longint unsigned q);
		return (p * q + Q30_ROUND) >> Q_FRAC;
	endfunction

	function automatic longint signed q30_to_angle(input longint unsigned q);
		return longint'((q + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT);
	endfunction

	function automatic atan_result_t predict_atan2(input logic signed [IN_W-1:0] xv,
			input logic signed [IN_W-1:0] yv);
		atan_result_t      res;
		longint signed     xs, ys, t, ang, hp, pi_a;
		longint unsigned   mag_x, mag_y, lo, hi, ratio, u1, u2, u3, u4, denom, tmag;
		logic              x_major;
		xs = xv;
		ys = yv;
		mag_x = (xs < 0) ? -xs : xs;
		mag_y = (ys < 0) ? -ys : ys;
		if (mag_x == 0 && mag_y == 0) begin
			res.angle     = '0;
			res.both_zero = 1'b1;
			return res;
		end
		x_major = mag_x > mag_y;
		lo = x_major ? mag_y : mag_x;
		hi = x_major ? mag_x : mag_y;
		ratio = ((lo << RATIO_FRAC) + (hi >> 1)) / hi;
		u1 = ratio * ratio;
		u2 = q30_product(u1, u1);
		u3 = q30_product(u2, u1);
		u4 = q30_product(u3, u1);
		denom = Q30_UNITY + q30_product(K_A, u1) + q30_product(K_C, u3)
			- q30_product(K_B, u2) - q30_product(K_D, u4);
		tmag = ((ratio << (RATIO_FRAC + ANGLE_FRAC)) + (denom >> 1)) / denom;
		t = longint'(tmag);
		// A zero minor component carries no sign, so the ratio stays positive.
		if (((xs < 0) != (ys < 0)) && lo != 0)
			t = -t;
		if (x_major) begin
			pi_a = q30_to_angle(PI_Q30);
			ang = t;
			if (xs < 0)
				ang = ang + ((ys >= 0) ? pi_a : -pi_a);
		end else begin
			hp = q30_to_angle(HALF_PI_Q30);
			ang = ((ys > 0) ? hp : -hp) - t;
		end
		res.angle     = ang[ANGLE_W-1:0];
		res.both_zero = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		atan_result_t want;
		if (!arst_n) begin
			expected_angles.delete();
			mismatches = 0;
			mismatch_count <= 0;
			results_due <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_angles.push_back(predict_atan2(x_value, y_value));
			if (out_valid && !out_stall) begin
				if (expected_angles.size() == 0) begin
					$error("unexpected result beat: angle %0d, both_zero %0b", angle,
						both_zero);
					mismatches++;
				end else begin
					want = expected_angles.pop_front();
					if (angle !== want.angle) begin
						$error("angle mismatch: expected %0d, got %0d", want.angle, angle);
						mismatches++;
					end
					if (both_zero !== want.both_zero) begin
						$error("both_zero mismatch: expected %0b, got %0b", want.both_zero,
							both_zero);
						mismatches++;
					end
				end
			end
			mismatch_count <= mismatches;
			results_due <= expected_angles.size();
		end
	end

endmodule

// File: tb/sv/atan2_rational_approx_core_tb.sv
`timescale 1ns / 100ps
// Top of the atan2 core testbench: clock, reset, input beats and receiver stalls,
// with the verdict. Depends on atan2ra_pkg, the core and the checker module.

module atan2_rational_approx_core_tb;
	import atan2ra_pkg::*;

	localparam int RANDOM_BEATS   = 1000;
	localparam int IDLE_LIMIT     = 3000;
	localparam int LONG_HOLD_AT   = 800;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 40;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        out_stall = 1'b0;
	logic signed [IN_W-1:0]      x_value   = '0;
	logic signed [IN_W-1:0]      y_value   = '0;
	logic                        in_stall;
	logic                        out_valid;
	logic signed [ANGLE_W-1:0]   angle;
	logic                        both_zero;
	int                          mismatch_count;
	int                          results_due;
	int                          idle_cycles = 0;
	int                          burst_mode  = 0;

	atan2_rational_approx_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_value   (x_value),
		.y_value   (y_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle     (angle),
		.both_zero (both_zero)
	);

	atan2_rational_approx_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.x_value        (x_value),
		.y_value        (y_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.angle          (angle),
		.both_zero      (both_zero),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("atan2_rational_approx_core verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap(input int mode);
		if (mode == 0 || $urandom_range(0, 9) < 7)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	// Offers one beat, with a random gap ahead of it, and returns at the falling
	// edge after it was taken.
	task automatic offer_vector(input logic signed [IN_W-1:0] x,
			input logic signed [IN_W-1:0] y);
		int gap;
		gap = pick_gap(burst_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		y_value <= y;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic pick_vector(output logic signed [IN_W-1:0] x,
			output logic signed [IN_W-1:0] y);
		logic signed [IN_W-1:0] m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				x = IN_W'($urandom);
				y = IN_W'($urandom);
			end
			4: begin
				x = IN_W'(int'($urandom_range(0, 16)) - 8);
				y = IN_W'(int'($urandom_range(0, 16)) - 8);
			end
			5: begin
				// Equal magnitudes, where y takes the lead.
				m = IN_W'($urandom);
				x = $urandom_range(0, 1) ? m : -m;
				y = $urandom_range(0, 1) ? m : -m;
			end
			6: begin
				m = IN_W'($urandom);
				x = $urandom_range(0, 1) ? m : '0;
				y = (x == 0) ? m : '0;
			end
			7: begin
				x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
				y = IN_W'($urandom);
				if ($urandom_range(0, 1)) begin
					m = x;
					x = y;
					y = m;
				end
			end
			8: begin
				x = IN_W'($urandom);
				y = x + IN_W'($urandom_range(0, 6) - 3);
			end
			default: begin
				x = IN_W'($urandom);
				y = IN_W'(int'($urandom_range(0, 64)) - 32);
			end
		endcase
	endtask

	initial begin : receiver
		int  cyc, hold, mode_left, stall_mode;
		logic next_stall;
		cyc = 0;
		hold = 0;
		mode_left = 0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == LONG_HOLD_AT)
				hold = LONG_HOLD;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = 250;
			end
			mode_left--;
			if (hold == 0 && stall_mode != 0
					&& $urandom_range(0, 99) < ((stall_mode == 1) ? 15 : 40))
				hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
					: $urandom_range(20, 60);
			next_stall = hold > 0;
			if (hold > 0)
				hold--;
			out_stall <= next_stall;
		end
	end

	initial begin : sender
		logic signed [IN_W-1:0] xs, ys;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_mode = 1;

		// Origin, axes, extremes, ties in every quadrant and the negative x axis.
		offer_vector(16'sd0, 16'sd0);
		offer_vector(16'sd32767, 16'sd0);
		offer_vector(-16'sd32768, 16'sd0);
		offer_vector(-16'sd5, 16'sd0);
		offer_vector(-16'sd1, 16'sd0);
		offer_vector(16'sd0, 16'sd32767);
		offer_vector(16'sd0, -16'sd32768);
		offer_vector(16'sd0, -16'sd1);
		offer_vector(16'sd1, 16'sd0);
		offer_vector(16'sd32767, 16'sd32767);
		offer_vector(-16'sd32768, -16'sd32768);
		offer_vector(16'sd1, 16'sd1);
		offer_vector(-16'sd1, -16'sd1);
		offer_vector(16'sd100, -16'sd100);
		offer_vector(-16'sd100, 16'sd100);
		offer_vector(-16'sd32768, 16'sd32767);
		offer_vector(16'sd32767, -16'sd32768);
		offer_vector(16'sd3, -16'sd7);
		offer_vector(-16'sd7, 16'sd3);
		offer_vector(16'sd1, -16'sd32768);
		offer_vector(-16'sd32768, 16'sd1);
		offer_vector(-16'sd32768, -16'sd1);
		offer_vector(16'sd32767, 16'sd1);
		offer_vector(-16'sd1, 16'sd32767);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 100 == 0)
				burst_mode = $urandom_range(0, 2);
			pick_vector(xs, ys);
			offer_vector(xs, ys);
		end
		in_valid <= 1'b0;

		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("atan2_rational_approx_core verification clean");
		else
			$display("atan2_rational_approx_core verification failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/atan2ra_pkg.sv
sv/atan2ra_ratio_div.sv
sv/atan2ra_atan_eval.sv
sv/atan2_rational_approx_core.sv
tb/sv/atan2_rational_approx_checker.sv
tb/sv/atan2_rational_approx_core_tb.sv
